[src/yuyv2bgr_pkg.sv]
// yuyv2bgr_pkg: payload structs, Q12 coefficients and clamp helper for the
// YUYV pair to BGR888 converter. No dependencies.
package yuyv2bgr_pkg;

  localparam int TermW = 24;

  typedef logic signed [TermW-1:0] term_t;

  localparam logic signed [TermW-1:0] KLuma   = 24'sd4768;
  localparam logic signed [TermW-1:0] KBlueU  = 24'sd8266;
  localparam logic signed [TermW-1:0] KGreenV = 24'sd3330;
  localparam logic signed [TermW-1:0] KGreenU = 24'sd1614;
  localparam logic signed [TermW-1:0] KRedV   = 24'sd6537;

  localparam logic [7:0] LumaOffset = 8'd16;
  localparam logic signed [TermW-1:0] ClampLimit = 24'sd1024000;
  localparam logic [7:0] ClampHigh = 8'd255;

  typedef struct packed {
    logic [7:0] first_luma;
    logic [7:0] blue_difference;
    logic [7:0] second_luma;
    logic [7:0] red_difference;
  } yuyv_t;

  typedef struct packed {
    logic [7:0] first_blue;
    logic [7:0] first_green;
    logic [7:0] first_red;
    logic [7:0] second_blue;
    logic [7:0] second_green;
    logic [7:0] second_red;
  } bgr_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // registered chroma products shared by both lanes
  typedef struct packed {
    term_t blue_u;
    term_t green_v;
    term_t green_u;
    term_t red_v;
  } chroma_terms_t;

  function automatic logic [7:0] clamp_q12(input term_t sum);
    logic [7:0] res;
    if (sum < 0) begin
      res = 8'd0;
    end else if (sum > ClampLimit) begin
      res = ClampHigh;
    end else begin
      res = sum[19:12];
    end
    return res;
  endfunction

endpackage

[src/yuyv2bgr_chroma.sv]
// yuyv2bgr_chroma: registered chroma products shared by both pixel lanes.
// Depends on yuyv2bgr_pkg.
module yuyv2bgr_chroma (
  input  logic                          clk,
  input  logic [7:0]                    blue_difference,
  input  logic [7:0]                    red_difference,
  output yuyv2bgr_pkg::chroma_terms_t   terms
);

  logic signed [7:0] du;
  logic signed [7:0] dv;

  // offset 128 removal is a flip of the top bit
  assign du = $signed({~blue_difference[7], blue_difference[6:0]});
  assign dv = $signed({~red_difference[7], red_difference[6:0]});

  always_ff @(posedge clk) begin
    terms.blue_u  <= yuyv2bgr_pkg::term_t'(du) * yuyv2bgr_pkg::KBlueU;
    terms.green_v <= yuyv2bgr_pkg::term_t'(dv) * yuyv2bgr_pkg::KGreenV;
    terms.green_u <= yuyv2bgr_pkg::term_t'(du) * yuyv2bgr_pkg::KGreenU;
    terms.red_v   <= yuyv2bgr_pkg::term_t'(dv) * yuyv2bgr_pkg::KRedV;
  end

endmodule

[src/yuyv2bgr_lane.sv]
// yuyv2bgr_lane: one pixel lane; registered luma product, then channel sums
// and clamp against the shared chroma terms. Depends on yuyv2bgr_pkg.
module yuyv2bgr_lane (
  input  logic                          clk,
  input  logic [7:0]                    luma,
  input  yuyv2bgr_pkg::chroma_terms_t   terms,
  output yuyv2bgr_pkg::pixel_t          pixel
);

  logic signed [8:0]   c;
  yuyv2bgr_pkg::term_t ly;
  yuyv2bgr_pkg::term_t blue_sum;
  yuyv2bgr_pkg::term_t green_sum;
  yuyv2bgr_pkg::term_t red_sum;

  assign c = $signed({1'b0, luma}) - $signed({1'b0, yuyv2bgr_pkg::LumaOffset});

  always_ff @(posedge clk) begin
    ly <= yuyv2bgr_pkg::term_t'(c) * yuyv2bgr_pkg::KLuma;
  end

  always_comb begin
    blue_sum    = ly + terms.blue_u;
    green_sum   = ly - terms.green_v - terms.green_u;
    red_sum     = ly + terms.red_v;
    pixel.blue  = yuyv2bgr_pkg::clamp_q12(blue_sum);
    pixel.green = yuyv2bgr_pkg::clamp_q12(green_sum);
    pixel.red   = yuyv2bgr_pkg::clamp_q12(red_sum);
  end

endmodule

[src/yuyv_pair_to_bgr888.sv]
// yuyv_pair_to_bgr888: YUYV group to two BGR888 pixels, BT.601 studio range.
// start reaches done through the prod_valid and done registers; one group per
// cycle sustained, set by the two-stage multiply then sum/clamp pipeline.
// busy is high only during reset; rst clears the valid pipeline.
// Results are shown for one cycle under done; the receiver cannot stall.
// Depends on yuyv2bgr_pkg, yuyv2bgr_chroma, yuyv2bgr_lane.
module yuyv_pair_to_bgr888 (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  yuyv2bgr_pkg::yuyv_t   yuyv,
  output logic                  done,
  output yuyv2bgr_pkg::bgr_t    bgr
);

  yuyv2bgr_pkg::chroma_terms_t terms;
  yuyv2bgr_pkg::pixel_t        first_px;
  yuyv2bgr_pkg::pixel_t        second_px;
  logic                        prod_valid;

  assign busy = rst;

  yuyv2bgr_chroma u_chroma (
    .clk             (clk),
    .blue_difference (yuyv.blue_difference),
    .red_difference  (yuyv.red_difference),
    .terms           (terms)
  );

  yuyv2bgr_lane u_lane_first (
    .clk   (clk),
    .luma  (yuyv.first_luma),
    .terms (terms),
    .pixel (first_px)
  );

  yuyv2bgr_lane u_lane_second (
    .clk   (clk),
    .luma  (yuyv.second_luma),
    .terms (terms),
    .pixel (second_px)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      prod_valid <= start && !busy;
      done       <= prod_valid;
    end
  end

  // merge the two lanes into the result transfer
  always_ff @(posedge clk) begin
    bgr.first_blue   <= first_px.blue;
    bgr.first_green  <= first_px.green;
    bgr.first_red    <= first_px.red;
    bgr.second_blue  <= second_px.blue;
    bgr.second_green <= second_px.green;
    bgr.second_red   <= second_px.red;
  end

endmodule

[src/yuyv2bgr_checker.sv]
// yuyv2bgr_checker: port-level assertions for yuyv_pair_to_bgr888, bound
// to the top level below. Depends on yuyv2bgr_pkg.
module yuyv2bgr_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input yuyv2bgr_pkg::yuyv_t   yuyv,
  input logic                  done,
  input yuyv2bgr_pkg::bgr_t    bgr
);

  // every result comes from a transfer that passed the prod_valid and done registers
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without matching input transfer");

  // every transfer yields a result through the prod_valid and done registers
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("input transfer lost");

  // clamp never lands between 251 and 254
  a_clamp_gap: assert property (@(posedge clk) disable iff (rst)
    done |-> ((bgr.first_blue < 8'd251 || bgr.first_blue == 8'd255) &&
              (bgr.first_green < 8'd251 || bgr.first_green == 8'd255) &&
              (bgr.first_red < 8'd251 || bgr.first_red == 8'd255) &&
              (bgr.second_blue < 8'd251 || bgr.second_blue == 8'd255) &&
              (bgr.second_green < 8'd251 || bgr.second_green == 8'd255) &&
              (bgr.second_red < 8'd251 || bgr.second_red == 8'd255)))
    else $error("channel value inside clamp gap");

  // equal lumas with shared chroma give identical pixels
  a_lane_match: assert property (@(posedge clk) disable iff (rst)
    (done && $past(yuyv.first_luma == yuyv.second_luma, 2)) |->
      (bgr.first_blue == bgr.second_blue && bgr.first_green == bgr.second_green &&
       bgr.first_red == bgr.second_red))
    else $error("lanes disagree on equal luma");

endmodule

bind yuyv_pair_to_bgr888 yuyv2bgr_checker u_checker (.*);
